[design/crr_pkg.sv]
package crr_pkg;

  localparam int TOWER_COUNT_DEF  = 32768;
  localparam int SECTOR_COUNT_DEF = 8;
  localparam int SCINT_SECTORS    = 6;

  typedef enum logic [1:0] {
    CMD_CLUSTER = 2'd0,
    CMD_TOWER   = 2'd1,
    CMD_GAIN    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  // field widths
  localparam int E_W    = 24;
  localparam int T_W    = 24;
  localparam int TWR_W  = 15;
  localparam int SEC_W  = 3;
  localparam int GAIN_W = 18;

  // nonlinearity terms, Q16
  localparam logic [16:0] A_SCINT = 17'd65733;
  localparam logic [16:0] A_GLASS = 17'd66912;
  localparam logic [10:0] K_SCINT = 11'd655;
  localparam logic [10:0] K_GLASS = 11'd1311;

  // divider: 64-bit dividend, 41-bit divisor, quotient known to stay below 2^44
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 41;
  localparam int DIV_QW = 44;
  localparam int REM_W  = DEN_W + 1;

  // square root of a 40-bit argument
  localparam int SQ_ARG_W = 40;
  localparam int SQ_W     = 20;
  localparam int SQ_REM_W = SQ_W + 3;

  // pT polynomial, Q16
  localparam logic [23:0] PT_OFFSET = 24'd46282;
  localparam logic [18:0] C_SQRT    = 19'd427819;
  localparam logic [16:0] C_LIN     = 17'd66454;
  localparam logic [9:0]  C_QUAD    = 10'd522;
  localparam logic signed [27:0] C_CONST = 28'sd313655;
  localparam logic signed [25:0] CORR_MIN = -26'sd255744;

endpackage

[design/crr_if.sv]
interface crr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  sector;
  logic [14:0] tower;
  logic [23:0] energy_in;
  logic [23:0] pt_in;
  logic signed [23:0] tof_in;
  logic signed [23:0] load_value;
  modport source(output valid, command, sector, tower, energy_in, pt_in, tof_in, load_value,
                 input ready);
  modport sink(input valid, command, sector, tower, energy_in, pt_in, tof_in, load_value,
               output ready);
endinterface

interface crr_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] energy_out;
  logic signed [23:0] tof_out;
  logic        energy_saturated;
  modport source(output valid, energy_out, tof_out, energy_saturated, input ready);
  modport sink(input valid, energy_out, tof_out, energy_saturated, output ready);
endinterface

interface crr_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[design/crr_ram.sv]
module crr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[design/crr_div.sv]
// Restoring divider, one quotient bit per stage.
module crr_div (
  input  logic                         clk,
  input  logic [crr_pkg::DIV_QW-1:0]   en,
  input  logic [crr_pkg::NUM_W-1:0]    num,
  input  logic [crr_pkg::DEN_W-1:0]    den,
  output logic [crr_pkg::DIV_QW-1:0]   quo
);

  typedef struct packed {
    logic [crr_pkg::REM_W-1:0]  rem;
    logic [crr_pkg::DIV_QW-1:0] nlow;
    logic [crr_pkg::DIV_QW-1:0] q;
    logic [crr_pkg::DEN_W-1:0]  den;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s);
    div_st_t r;
    logic [crr_pkg::REM_W-1:0] sh;
    logic ge;
    sh = {s.rem[crr_pkg::REM_W-2:0], s.nlow[crr_pkg::DIV_QW-1]};
    ge = (sh >= crr_pkg::REM_W'(s.den));
    r.rem  = ge ? sh - crr_pkg::REM_W'(s.den) : sh;
    r.nlow = {s.nlow[crr_pkg::DIV_QW-2:0], 1'b0};
    r.q    = {s.q[crr_pkg::DIV_QW-2:0], ge};
    r.den  = s.den;
    return r;
  endfunction

  div_st_t init;
  div_st_t st [crr_pkg::DIV_QW];

  always_comb begin
    init.rem  = crr_pkg::REM_W'(num[crr_pkg::NUM_W-1:crr_pkg::DIV_QW]);
    init.nlow = num[crr_pkg::DIV_QW-1:0];
    init.q    = '0;
    init.den  = den;
  end

  for (genvar j = 0; j < crr_pkg::DIV_QW; j++) begin : g_st
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[j]) st[j] <= div_step(init);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[j]) st[j] <= div_step(st[j-1]);
      end
    end
  end

  assign quo = st[crr_pkg::DIV_QW-1].q;

endmodule

[design/crr_sqrt.sv]
// Integer square root, two argument bits per stage.
module crr_sqrt (
  input  logic                          clk,
  input  logic [crr_pkg::SQ_W-1:0]      en,
  input  logic [crr_pkg::SQ_ARG_W-1:0]  arg,
  output logic [crr_pkg::SQ_W-1:0]      root
);

  typedef struct packed {
    logic [crr_pkg::SQ_REM_W-1:0] rem;
    logic [crr_pkg::SQ_W-1:0]     root;
    logic [crr_pkg::SQ_ARG_W-1:0] argl;
  } sq_st_t;

  function automatic sq_st_t sq_step(sq_st_t s);
    sq_st_t r;
    logic [crr_pkg::SQ_REM_W-1:0] sh;
    logic [crr_pkg::SQ_REM_W-1:0] trial;
    logic ge;
    sh    = {s.rem[crr_pkg::SQ_REM_W-3:0], s.argl[crr_pkg::SQ_ARG_W-1 -: 2]};
    trial = crr_pkg::SQ_REM_W'({s.root, 2'b01});
    ge    = (sh >= trial);
    r.rem  = ge ? sh - trial : sh;
    r.root = {s.root[crr_pkg::SQ_W-2:0], ge};
    r.argl = {s.argl[crr_pkg::SQ_ARG_W-3:0], 2'b00};
    return r;
  endfunction

  sq_st_t init;
  sq_st_t st [crr_pkg::SQ_W];

  always_comb begin
    init.rem  = '0;
    init.root = '0;
    init.argl = arg;
  end

  for (genvar j = 0; j < crr_pkg::SQ_W; j++) begin : g_st
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[j]) st[j] <= sq_step(init);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[j]) st[j] <= sq_step(st[j-1]);
      end
    end
  end

  assign root = st[crr_pkg::SQ_W-1].root;

endmodule

[design/calorimeter_cluster_recalibrator_core.sv]
// Cluster recalibrator. Takes one item per cycle while the pipeline is not stalled
// by result.ready and returns one result per cluster item, in order (3 front
// stages, a 44-stage restoring divider for the energy nonlinearity, 3 back stages;
// the pT square root runs alongside the divider). Table and gain writes are taken
// at the same rate and produce no result; a cluster sees every write taken
// before it. After reset the tower time table (one RAM write port) is cleared
// one entry per cycle, all TOWER_COUNT entries (32768 by default), during which no
// item is taken; ert_mode writes are accepted at any time.
module calorimeter_cluster_recalibrator_core #(
  parameter int TOWER_COUNT  = crr_pkg::TOWER_COUNT_DEF,
  parameter int SECTOR_COUNT = crr_pkg::SECTOR_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  crr_in_if.sink    cluster,
  crr_out_if.source result,
  crr_cfg_if.sink   cfg
);

  localparam int AW  = $clog2(TOWER_COUNT);
  localparam int SW  = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
  localparam int QW  = crr_pkg::DIV_QW;
  localparam int P1  = 3 + QW;
  localparam int NST = P1 + 3;

  typedef struct packed {
    logic signed [23:0] tof;
    logic signed [23:0] tbl;
    logic [17:0]        gain;
    logic               ptsel;
    logic               dpos;
    logic [24:0]        p66h;
    logic [25:0]        pp522h;
    logic [19:0]        s;
  } side_t;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  logic          ert_mode;
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic [17:0]   gain_mem [SECTOR_COUNT];

  logic          accept;
  logic          is_cluster;
  logic          tower_ok;
  logic          sector_ok;
  logic [AW-1:0] tower_addr;
  logic [SW-1:0] sector_idx;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [23:0]   ram_wdata;
  logic [23:0]   ram_rdata;

  // stall only where every stage from here to the output is full
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = result.ready | ~(&v[NST-1:k]);
  end

  assign cfg.ready     = 1'b1;
  assign cluster.ready = en[0] & ~clearing;
  assign accept        = cluster.valid & cluster.ready;
  assign is_cluster    = (cluster.command == crr_pkg::CMD_CLUSTER);
  assign tower_ok      = (32'(cluster.tower) < TOWER_COUNT);
  assign sector_ok     = (32'(cluster.sector) < SECTOR_COUNT);
  assign tower_addr    = AW'(cluster.tower);
  assign sector_idx    = SW'(cluster.sector);

  always_ff @(posedge clk) begin
    if (rst) begin
      ert_mode <= 1'b1;
    end else if (cfg.valid) begin
      ert_mode <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(TOWER_COUNT - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SECTOR_COUNT; i++) gain_mem[i] <= '0;
    end else if (accept && cluster.command == crr_pkg::CMD_GAIN && sector_ok) begin
      gain_mem[sector_idx] <= cluster.load_value[17:0];
    end
  end

  assign ram_we    = clearing | (accept & (cluster.command == crr_pkg::CMD_TOWER) & tower_ok);
  assign ram_waddr = clearing ? clr_addr : tower_addr;
  assign ram_wdata = clearing ? 24'd0 : cluster.load_value;

  crr_ram #(.WIDTH(24), .DEPTH(TOWER_COUNT)) u_tof_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept & is_cluster),
    .raddr(tower_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= accept & is_cluster;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: capture, gain lookup, table read in flight
  logic [23:0]        s1_e, s1_p;
  logic signed [23:0] s1_tof;
  logic               s1_tvalid, s1_scint, s1_ptsel;
  logic [17:0]        s1_gain;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_e      <= cluster.energy_in;
      s1_p      <= cluster.pt_in;
      s1_tof    <= cluster.tof_in;
      s1_tvalid <= tower_ok;
      s1_scint  <= (32'(cluster.sector) < crr_pkg::SCINT_SECTORS);
      s1_ptsel  <= ert_mode & (32'(cluster.sector) < crr_pkg::SCINT_SECTORS);
      s1_gain   <= sector_ok ? gain_mem[sector_idx] : 18'd0;
    end
  end

  // stage 2: products
  logic [47:0]        s2_e2, s2_pp;
  logic [40:0]        s2_ea, s2_p66;
  logic [23:0]        s2_a;
  logic               s2_scint, s2_ptsel;
  logic signed [23:0] s2_tof, s2_tbl;
  logic [17:0]        s2_gain;
  logic [47:0]        e2_c, pp_c;
  logic [40:0]        ea_c, p66_c;

  assign e2_c  = s1_e * s1_e;
  assign ea_c  = s1_e * (s1_scint ? crr_pkg::A_SCINT : crr_pkg::A_GLASS);
  assign pp_c  = s1_p * s1_p;
  assign p66_c = s1_p * crr_pkg::C_LIN;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_e2    <= e2_c;
      s2_ea    <= ea_c;
      s2_pp    <= pp_c;
      s2_p66   <= p66_c;
      s2_a     <= (s1_p > crr_pkg::PT_OFFSET) ? s1_p - crr_pkg::PT_OFFSET : 24'd0;
      s2_scint <= s1_scint;
      s2_ptsel <= s1_ptsel;
      s2_tof   <= s1_tof;
      s2_tbl   <= s1_tvalid ? ram_rdata : 24'sd0;
      s2_gain  <= s1_gain;
    end
  end

  // stage 3: denominator, quadratic term
  logic [63:0]        s3_num;
  logic [40:0]        s3_den;
  logic               s3_dpos, s3_ptsel;
  logic [39:0]        s3_sqarg;
  logic [24:0]        s3_p66h;
  logic [25:0]        s3_pp522h;
  logic signed [23:0] s3_tof, s3_tbl;
  logic [17:0]        s3_gain;
  logic [40:0]        kshift;
  logic [57:0]        pp522_c;

  assign kshift  = 41'({(s2_scint ? crr_pkg::K_SCINT : crr_pkg::K_GLASS), 16'd0});
  assign pp522_c = s2_pp * crr_pkg::C_QUAD;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_num    <= {s2_e2, 16'd0};
      s3_den    <= s2_ea - kshift;
      s3_dpos   <= (s2_ea > kshift);
      s3_sqarg  <= {s2_a, 16'd0};
      s3_p66h   <= s2_p66[40:16];
      s3_pp522h <= pp522_c[57:32];
      s3_ptsel  <= s2_ptsel;
      s3_tof    <= s2_tof;
      s3_tbl    <= s2_tbl;
      s3_gain   <= s2_gain;
    end
  end

  // divider and square root, side data kept in step with the divider
  logic [QW-1:0]             quo;
  logic [crr_pkg::SQ_W-1:0]  sq_root;
  side_t                     side0;
  side_t                     side [QW];

  crr_div u_div (
    .clk(clk),
    .en (en[3 +: QW]),
    .num(s3_num),
    .den(s3_den),
    .quo(quo)
  );

  crr_sqrt u_sqrt (
    .clk (clk),
    .en  (en[3 +: crr_pkg::SQ_W]),
    .arg (s3_sqarg),
    .root(sq_root)
  );

  always_comb begin
    side0.tof    = s3_tof;
    side0.tbl    = s3_tbl;
    side0.gain   = s3_gain;
    side0.ptsel  = s3_ptsel;
    side0.dpos   = s3_dpos;
    side0.p66h   = s3_p66h;
    side0.pp522h = s3_pp522h;
    side0.s      = '0;
  end

  for (genvar j = 0; j < QW; j++) begin : g_side
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[3]) side[0] <= side0;
      end
    end else if (j == crr_pkg::SQ_W) begin : g_root
      // root is the low field of the side record
      always_ff @(posedge clk) begin
        if (en[3+j]) begin
          side[j] <= side_t'({side[j-1][$bits(side_t)-1:crr_pkg::SQ_W], sq_root});
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[3+j]) side[j] <= side[j-1];
      end
    end
  end

  // back stage 1: gain and sqrt products
  logic               p1_ovf, p1_dpos, p1_gzero, p1_ptsel;
  logic [57:0]        p1_rg;
  logic [38:0]        p1_sq;
  logic signed [23:0] p1_tof, p1_tbl;
  logic [24:0]        p1_p66h;
  logic [25:0]        p1_pp522h;
  logic [57:0]        rg_c;
  logic [38:0]        sq_c;

  assign rg_c = quo[39:0] * side[QW-1].gain;
  assign sq_c = side[QW-1].s * crr_pkg::C_SQRT;

  always_ff @(posedge clk) begin
    if (en[P1]) begin
      p1_ovf    <= |quo[QW-1:40];
      p1_rg     <= rg_c;
      p1_sq     <= sq_c;
      p1_dpos   <= side[QW-1].dpos;
      p1_gzero  <= (side[QW-1].gain == 18'd0);
      p1_ptsel  <= side[QW-1].ptsel;
      p1_tof    <= side[QW-1].tof;
      p1_tbl    <= side[QW-1].tbl;
      p1_p66h   <= side[QW-1].p66h;
      p1_pp522h <= side[QW-1].pp522h;
    end
  end

  // back stage 2: energy select, total correction
  logic [23:0]        p2_eout;
  logic               p2_esat;
  logic signed [25:0] p2_corr;
  logic signed [23:0] p2_tof;
  logic [41:0]        rgh;
  logic signed [27:0] f_c;
  logic signed [19:0] f8_c;
  logic [23:0]        eout_c;
  logic               esat_c;

  assign rgh  = p1_rg[57:16];
  assign f_c  = $signed({5'd0, p1_sq[38:16]}) - crr_pkg::C_CONST
              - $signed({3'd0, p1_p66h}) + $signed({2'd0, p1_pp522h});
  assign f8_c = f_c[27:8];   // floor divide by 256

  always_comb begin
    if (!p1_dpos) begin
      eout_c = 24'hFFFFFF;
      esat_c = 1'b1;
    end else if (p1_gzero) begin
      eout_c = 24'd0;
      esat_c = 1'b0;
    end else if (p1_ovf || (|rgh[41:24])) begin
      eout_c = 24'hFFFFFF;
      esat_c = 1'b1;
    end else begin
      eout_c = rgh[23:0];
      esat_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[P1+1]) begin
      p2_eout <= eout_c;
      p2_esat <= esat_c;
      p2_corr <= 26'(p1_tbl) + (p1_ptsel ? 26'(f8_c) : 26'sd0);
      p2_tof  <= p1_tof;
    end
  end

  // back stage 3: time subtract and saturate, output register
  logic signed [25:0] corr_c;
  logic signed [26:0] t_c;
  logic signed [23:0] tsat_c;

  assign corr_c = (p2_corr < crr_pkg::CORR_MIN) ? 26'sd0 : p2_corr;
  assign t_c    = 27'(p2_tof) - 27'(corr_c);

  always_comb begin
    if (t_c > 27'sd8388607) tsat_c = 24'sh7FFFFF;
    else if (t_c < -27'sd8388608) tsat_c = 24'sh800000;
    else tsat_c = t_c[23:0];
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      result.energy_out       <= p2_eout;
      result.energy_saturated <= p2_esat;
      result.tof_out          <= tsat_c;
    end
  end

  assign result.valid = v[NST-1];

endmodule

[design/crr_checker.sv]
module crr_checker (
  input logic        clk,
  input logic        rst,
  input logic        cluster_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [23:0] energy_out,
  input logic [23:0] tof_out,
  input logic        energy_saturated
);

  // table clear keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk) rst |=> !cluster_ready)
    else $error("item taken during table clear");

  a_no_result_after_rst: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result shown right after reset");

  a_stall_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_stall_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(energy_out) && $stable(tof_out) && $stable(energy_saturated))
    else $error("result changed while stalled");

endmodule

bind calorimeter_cluster_recalibrator_core crr_checker u_crr_checker (
  .clk             (clk),
  .rst             (rst),
  .cluster_ready   (cluster.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .energy_out      (result.energy_out),
  .tof_out         (result.tof_out),
  .energy_saturated(result.energy_saturated)
);
